[rtl/sliding_window_maximum_assert.svh]
// Assertion macros for the sliding window maximum block.
// Included by the port checker; needs nothing else.
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swm_pkg.sv]
// Shared types and constants of the sliding window maximum block.
// No dependencies; imported by every module of the block.
`default_nettype none

package swm_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic fresh;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/sliding_window_maximum.sv]
// Top level of the sliding window maximum block: cell chain, window counter, output register.
// Depends on swm_pkg and swm_cell.
//
//   channel   direction   tdata / data bits          tuser bits
//   s_axis    in          [31:0] sample              [0] start_stream
//   m_axis    out         [31:0] window_max          -
//   cfg       in          [6:0] window_size          -
//
// One word is taken per clock while the output register is not stalled; its result, if any,
// appears in the output register in the cycle after acceptance. The cell chain updates all cells in the same cycle.
// Reset clears the window counter, the stream flag and the output valid; the window
// size resets to one. A stalled output holds its word and blocks input only while full.
`default_nettype none

module sliding_window_maximum #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [swm_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] sample
  input  logic [0:0]                  s_axis_tuser,   // [0] start_stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [swm_pkg::DATA_W-1:0]  m_axis_tdata,   // [31:0] window_max
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_data_i
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CFG_W-1:0] cfg_q;
  logic [CW-1:0]    seen_q;
  logic [CW-1:0]    seen_d;
  logic             live_q;
  logic             out_valid_q;
  sample_t          out_data_q;
  sample_t          out_data_d;

  logic [EW-1:0] cfg_ext;
  logic [EW-1:0] win_eff;
  logic [EW-1:0] seen_clip;
  logic [EW-1:0] seen_next;
  logic [IW-1:0] tap_idx;
  logic          accept;
  logic          emit;
  sample_t       sample;
  sample_t       tap_val;
  cell_ctl_t     ctl;
  sample_t       cell_max [MAX_WINDOW];

  assign sample        = $signed(s_axis_tdata);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign ctl.load  = accept;
  assign ctl.fresh = s_axis_tuser[0] || !live_q;

  always_comb begin
    cfg_ext = EW'(cfg_q);
    if (cfg_ext == '0) begin
      win_eff = EW'(1);
    end else if (cfg_ext > EW'(MAX_WINDOW)) begin
      win_eff = EW'(MAX_WINDOW);
    end else begin
      win_eff = cfg_ext;
    end

    if (s_axis_tuser[0]) begin
      seen_clip = '0;
    end else if (EW'(seen_q) > win_eff) begin
      seen_clip = win_eff;
    end else begin
      seen_clip = EW'(seen_q);
    end
    seen_next = (seen_clip < win_eff) ? seen_clip + EW'(1) : win_eff;
    seen_d    = CW'(seen_next);
    emit      = (seen_next == win_eff);

    tap_idx = IW'(win_eff - EW'(2));
    tap_val = cell_max[tap_idx];
    if (win_eff == EW'(1) || ctl.fresh) begin
      out_data_d = sample;
    end else if (tap_val > sample) begin
      out_data_d = tap_val;
    end else begin
      out_data_d = sample;
    end
  end

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swm_cell #(
      .FIRST (k == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .sample_i (sample),
      .prev_i   (cell_max[(k == 0) ? 0 : k - 1]),
      .max_o    (cell_max[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_W'(1);
      seen_q      <= '0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (accept) begin
        seen_q <= seen_d;
        live_q <= 1'b1;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[rtl/swm_cell.sv]
// One cell of the running-maximum chain: holds the maximum of the newest k+1 words.
// Depends on swm_pkg.
`default_nettype none

module swm_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic               clk_i,
  input  swm_pkg::cell_ctl_t ctl_i,
  input  swm_pkg::sample_t   sample_i,
  input  swm_pkg::sample_t   prev_i,
  output swm_pkg::sample_t   max_o
);
  import swm_pkg::*;

  sample_t max_q;
  sample_t max_d;

  always_comb begin
    if (FIRST || ctl_i.fresh) begin
      max_d = sample_i;
    end else if (prev_i > sample_i) begin
      max_d = prev_i;
    end else begin
      max_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

`default_nettype wire

[rtl/swm_checker.sv]
// Port-level checker for the sliding window maximum block, with its bind statement.
// Depends on swm_pkg and sliding_window_maximum_assert.svh.
`default_nettype none

`include "sliding_window_maximum_assert.svh"

module swm_checker #(
  parameter int MAX_WINDOW = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [swm_pkg::DATA_W-1:0]  s_axis_tdata,
  input logic [0:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [swm_pkg::DATA_W-1:0]  m_axis_tdata,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [swm_pkg::CFG_W-1:0]   cfg_data_i
);
  import swm_pkg::*;

  logic [CFG_W-1:0] win_q;
  logic             s_acc;
  logic             win_one;
  logic             win_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_q <= cfg_data_i;
    end
  end

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign win_one  = (win_q == CFG_W'(0)) || (win_q == CFG_W'(1)) || (MAX_WINDOW == 1);
  assign win_wide = !win_one;

  `SWM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

  `SWM_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready,
    "input stalled with an empty output register")

  `SWM_ASSERT_NEXT(a_unit_window, clk_i, rst_ni, s_acc && win_one,
    m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata)), "window of one did not pass the word")

  `SWM_ASSERT_NEXT(a_start_silent, clk_i, rst_ni, s_acc && s_axis_tuser[0] && win_wide,
    !m_axis_tvalid, "first word of a stream produced a result")

endmodule

bind sliding_window_maximum swm_checker #(
  .MAX_WINDOW (MAX_WINDOW)
) u_swm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_data_i    (cfg_data_i)
);

`default_nettype wire
